// ----- hw/rtl/mlf_pkg.sv -----
// ----------------------------------------------------------------------------
// mlf_pkg: shared types and constants of the ladder lowpass filter
// Word widths, register indexes, sequencer states and the command bundle
// passed from the controller to the datapath.
// ----------------------------------------------------------------------------
package mlf_pkg;

   // default parameter values
   localparam int SAMPLE_BITS_DEF    = 24;
   localparam int COEF_FRAC_BITS_DEF = 20;

   // fixed word widths
   localparam int DATA_W    = 32;           // internal state format
   localparam int COEF_W    = 24;           // coefficient registers
   localparam int SUM_W     = DATA_W + 1;   // stage input sum, multiplier operand
   localparam int PROD_W    = 2 * SUM_W;    // product and accumulator
   localparam int CSR_IDX_W = 2;

   // y^3/6 reciprocal: round(2^22 / 6)
   localparam int SIXTH_Q     = 699051;
   localparam int SIXTH_SHIFT = 22;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_POLE     = 2'd0,
      CSR_FEEDBACK = 2'd1,
      CSR_RESON    = 2'd2
   } csr_index_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FB_MUL,
      ST_FB_RND,
      ST_X,
      ST_SUM,
      ST_MUL_P,
      ST_MUL_K,
      ST_SUB,
      ST_RND,
      ST_SQ_MUL,
      ST_SQ_RND,
      ST_CU_MUL,
      ST_CU_RND,
      ST_SX_MUL,
      ST_SX_RND,
      ST_FIN
   } state_type;

   // multiplier operand pairs
   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_FB,      // r * s4
      MUL_POLE,    // p * stage sum
      MUL_FEED,    // k * old stage output
      MUL_SQ,      // y * y
      MUL_CU,      // sq * y
      MUL_SIXTH    // cube * 1/6
   } mul_op_type;

   // round and saturate steps
   typedef enum logic [2:0] {
      RND_NONE,
      RND_FB,      // product >> coef frac, into temp
      RND_STAGE,   // accumulator >> coef frac, into current
      RND_SQ,      // product >> sample frac, into temp
      RND_SIXTH    // product >> 22, into temp
   } rnd_op_type;

   // controller to datapath command bundle
   typedef struct packed {
      logic       load_sample;
      mul_op_type mul_op;
      rnd_op_type rnd_op;
      logic       x_en;
      logic       sum_en;
      logic       acc_load;
      logic       acc_sub;
      logic       fin_en;
      logic [1:0] stage;
   } cmd_type;

endpackage

// ----- hw/rtl/mlf_if.sv -----
// ----------------------------------------------------------------------------
// mlf interfaces: request, response and register write channels
// Each channel carries valid, ready and its payload, with source and sink
// modports.
// ----------------------------------------------------------------------------
interface mlf_req_if #(
   parameter int WIDTH = mlf_pkg::SAMPLE_BITS_DEF
);
   logic                    valid;
   logic                    ready;
   logic signed [WIDTH-1:0] sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

interface mlf_rsp_if #(
   parameter int WIDTH = mlf_pkg::SAMPLE_BITS_DEF
);
   logic                    valid;
   logic                    ready;
   logic signed [WIDTH-1:0] sample_out;

   modport source (output valid, output sample_out, input ready);
   modport sink   (input valid, input sample_out, output ready);
endinterface

interface mlf_csr_if;
   logic                                valid;
   logic                                ready;
   logic [mlf_pkg::CSR_IDX_W-1:0]       reg_index;
   logic [mlf_pkg::COEF_W-1:0]          wdata;

   modport source (output valid, output reg_index, output wdata, input ready);
   modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// ----- hw/rtl/mlf_ctrl.sv -----
// ----------------------------------------------------------------------------
// mlf_ctrl: sequencer of the ladder filter
// Steps the shared multiplier through feedback, four stages and the soft
// clip, and owns the request and response handshakes.
// ----------------------------------------------------------------------------
module mlf_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mlf_pkg::cmd_type cmd
);

   mlf_pkg::state_type state_ff, state_in;
   logic [1:0]         stage_ff, stage_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               req_fire;
   logic               fin_go;

   assign req_ready = (state_ff == mlf_pkg::ST_IDLE);
   assign req_fire  = req_valid & req_ready;
   // result may be written once the output register is free or being drained
   assign fin_go    = ~rsp_valid_ff | rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mlf_pkg::ST_IDLE:   if (req_fire) state_in = mlf_pkg::ST_FB_MUL;
         mlf_pkg::ST_FB_MUL: state_in = mlf_pkg::ST_FB_RND;
         mlf_pkg::ST_FB_RND: state_in = mlf_pkg::ST_X;
         mlf_pkg::ST_X:      state_in = mlf_pkg::ST_SUM;
         mlf_pkg::ST_SUM:    state_in = mlf_pkg::ST_MUL_P;
         mlf_pkg::ST_MUL_P:  state_in = mlf_pkg::ST_MUL_K;
         mlf_pkg::ST_MUL_K:  state_in = mlf_pkg::ST_SUB;
         mlf_pkg::ST_SUB:    state_in = mlf_pkg::ST_RND;
         mlf_pkg::ST_RND: begin
            if (stage_ff == 2'd3) state_in = mlf_pkg::ST_SQ_MUL;
            else                  state_in = mlf_pkg::ST_SUM;
         end
         mlf_pkg::ST_SQ_MUL: state_in = mlf_pkg::ST_SQ_RND;
         mlf_pkg::ST_SQ_RND: state_in = mlf_pkg::ST_CU_MUL;
         mlf_pkg::ST_CU_MUL: state_in = mlf_pkg::ST_CU_RND;
         mlf_pkg::ST_CU_RND: state_in = mlf_pkg::ST_SX_MUL;
         mlf_pkg::ST_SX_MUL: state_in = mlf_pkg::ST_SX_RND;
         mlf_pkg::ST_SX_RND: state_in = mlf_pkg::ST_FIN;
         mlf_pkg::ST_FIN:    if (fin_go) state_in = mlf_pkg::ST_IDLE;
         default:            state_in = mlf_pkg::ST_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd             = '0;
      cmd.mul_op      = mlf_pkg::MUL_NONE;
      cmd.rnd_op      = mlf_pkg::RND_NONE;
      cmd.stage       = stage_ff;
      unique case (state_ff)
         mlf_pkg::ST_IDLE:   cmd.load_sample = req_fire;
         mlf_pkg::ST_FB_MUL: cmd.mul_op = mlf_pkg::MUL_FB;
         mlf_pkg::ST_FB_RND: cmd.rnd_op = mlf_pkg::RND_FB;
         mlf_pkg::ST_X:      cmd.x_en = 1'b1;
         mlf_pkg::ST_SUM:    cmd.sum_en = 1'b1;
         mlf_pkg::ST_MUL_P:  cmd.mul_op = mlf_pkg::MUL_POLE;
         mlf_pkg::ST_MUL_K: begin
            cmd.mul_op   = mlf_pkg::MUL_FEED;
            cmd.acc_load = 1'b1;
         end
         mlf_pkg::ST_SUB:    cmd.acc_sub = 1'b1;
         mlf_pkg::ST_RND:    cmd.rnd_op = mlf_pkg::RND_STAGE;
         mlf_pkg::ST_SQ_MUL: cmd.mul_op = mlf_pkg::MUL_SQ;
         mlf_pkg::ST_SQ_RND: cmd.rnd_op = mlf_pkg::RND_SQ;
         mlf_pkg::ST_CU_MUL: cmd.mul_op = mlf_pkg::MUL_CU;
         mlf_pkg::ST_CU_RND: cmd.rnd_op = mlf_pkg::RND_SQ;
         mlf_pkg::ST_SX_MUL: cmd.mul_op = mlf_pkg::MUL_SIXTH;
         mlf_pkg::ST_SX_RND: cmd.rnd_op = mlf_pkg::RND_SIXTH;
         mlf_pkg::ST_FIN:    cmd.fin_en = fin_go;
         default:            cmd.load_sample = 1'b0;
      endcase
   end

   // stage counter and response valid
   always_comb begin
      stage_in = stage_ff;
      if (state_ff == mlf_pkg::ST_X)   stage_in = 2'd0;
      if (state_ff == mlf_pkg::ST_RND) stage_in = stage_ff + 2'd1;

      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      if (state_ff == mlf_pkg::ST_FIN && fin_go) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mlf_pkg::ST_IDLE;
         stage_ff     <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         stage_ff     <= stage_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- hw/rtl/mlf_datapath.sv -----
// ----------------------------------------------------------------------------
// mlf_datapath: arithmetic and state of the ladder filter
// One shared signed multiplier, an accumulator, round and saturate logic,
// the filter state, the coefficient registers and the output register.
// ----------------------------------------------------------------------------
module mlf_datapath #(
   parameter int SAMPLE_BITS    = mlf_pkg::SAMPLE_BITS_DEF,
   parameter int COEF_FRAC_BITS = mlf_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  mlf_pkg::cmd_type                 cmd,
   input  logic signed [SAMPLE_BITS-1:0]    sample_in,
   input  logic                             csr_write,
   input  logic [mlf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mlf_pkg::COEF_W-1:0]       csr_wdata,
   output logic signed [SAMPLE_BITS-1:0]    sample_out
);

   localparam int DW = mlf_pkg::DATA_W;
   localparam int SW = mlf_pkg::SUM_W;
   localparam int PW = mlf_pkg::PROD_W;
   localparam int CW = mlf_pkg::COEF_W;

   localparam logic signed [DW-1:0] D_MAX = {1'b0, {(DW-1){1'b1}}};
   localparam logic signed [DW-1:0] D_MIN = {1'b1, {(DW-1){1'b0}}};
   localparam logic signed [DW:0]   S_MAX = (33'sd1 <<< (SAMPLE_BITS - 1)) - 33'sd1;
   localparam logic signed [DW:0]   S_MIN = -S_MAX - 33'sd1;
   localparam logic signed [SW-1:0] SIXTH = SW'(mlf_pkg::SIXTH_Q);

   // saturate a wide value to the internal format
   function automatic logic signed [DW-1:0] sat32(input logic signed [PW-1:0] v);
      logic signed [DW-1:0] r;
      if (v > PW'(D_MAX))      r = D_MAX;
      else if (v < PW'(D_MIN)) r = D_MIN;
      else                     r = v[DW-1:0];
      return r;
   endfunction

   // add half, floor shift, saturate
   function automatic logic signed [DW-1:0] round_sat(input logic signed [PW-1:0] v,
                                                      input int sh);
      logic signed [PW-1:0] t;
      t = v + (PW'(1) <<< (sh - 1));
      t = t >>> sh;
      return sat32(t);
   endfunction

   logic signed [CW-1:0]          pole_ff, feed_ff, reson_ff;
   logic signed [SAMPLE_BITS-1:0] smp_ff;
   logic signed [DW-1:0]          xprev_ff, s1_ff, s2_ff, s3_ff, s4_ff;
   logic signed [DW-1:0]          cur_ff, tmp_ff;
   logic signed [SW-1:0]          sum_ff;
   logic signed [PW-1:0]          prod_ff, acc_ff;
   logic signed [SAMPLE_BITS-1:0] out_ff;

   logic signed [SW-1:0] op_a, op_b;
   logic signed [DW-1:0] prev_sel, own_sel;
   logic signed [DW-1:0] smp_ext;
   logic signed [SW-1:0] x_diff;
   logic signed [SW-1:0] y_diff;
   logic signed [DW-1:0] y_new;
   logic signed [DW:0]   y_wide;
   logic signed [DW-1:0] rnd_val;

   // stage taps: previous input and own previous output
   always_comb begin
      case (cmd.stage)
         2'd0:    begin prev_sel = xprev_ff; own_sel = s1_ff; end
         2'd1:    begin prev_sel = s1_ff;    own_sel = s2_ff; end
         2'd2:    begin prev_sel = s2_ff;    own_sel = s3_ff; end
         default: begin prev_sel = s3_ff;    own_sel = s4_ff; end
      endcase
   end

   // multiplier operand select
   always_comb begin
      case (cmd.mul_op)
         mlf_pkg::MUL_FB:    begin op_a = SW'(reson_ff); op_b = SW'(s4_ff);   end
         mlf_pkg::MUL_POLE:  begin op_a = SW'(pole_ff);  op_b = sum_ff;       end
         mlf_pkg::MUL_FEED:  begin op_a = SW'(feed_ff);  op_b = SW'(own_sel); end
         mlf_pkg::MUL_SQ:    begin op_a = SW'(cur_ff);   op_b = SW'(cur_ff);  end
         mlf_pkg::MUL_CU:    begin op_a = SW'(tmp_ff);   op_b = SW'(cur_ff);  end
         mlf_pkg::MUL_SIXTH: begin op_a = SW'(tmp_ff);   op_b = SIXTH;        end
         default:            begin op_a = '0;            op_b = '0;           end
      endcase
   end

   // round step source and shift
   always_comb begin
      case (cmd.rnd_op)
         mlf_pkg::RND_FB:    rnd_val = round_sat(prod_ff, COEF_FRAC_BITS);
         mlf_pkg::RND_STAGE: rnd_val = round_sat(acc_ff, COEF_FRAC_BITS);
         mlf_pkg::RND_SQ:    rnd_val = round_sat(prod_ff, SAMPLE_BITS - 1);
         mlf_pkg::RND_SIXTH: rnd_val = round_sat(prod_ff, mlf_pkg::SIXTH_SHIFT);
         default:            rnd_val = '0;
      endcase
   end

   // input stage and final soft clip subtraction
   assign smp_ext = DW'(smp_ff);
   assign x_diff  = SW'(smp_ext) - SW'(tmp_ff);
   assign y_diff  = SW'(cur_ff) - SW'(tmp_ff);
   assign y_new   = sat32(PW'(y_diff));
   assign y_wide  = (DW + 1)'(y_new);

   // coefficient registers and filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         pole_ff  <= '0;
         feed_ff  <= '0;
         reson_ff <= '0;
         xprev_ff <= '0;
         s1_ff    <= '0;
         s2_ff    <= '0;
         s3_ff    <= '0;
         s4_ff    <= '0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               mlf_pkg::CSR_POLE:     pole_ff  <= csr_wdata;
               mlf_pkg::CSR_FEEDBACK: feed_ff  <= csr_wdata;
               mlf_pkg::CSR_RESON:    reson_ff <= csr_wdata;
               default:               ;
            endcase
         end
         // old stage input is replaced once the sum has taken it
         if (cmd.sum_en) begin
            case (cmd.stage)
               2'd0:    xprev_ff <= cur_ff;
               2'd1:    s1_ff    <= cur_ff;
               2'd2:    s2_ff    <= cur_ff;
               default: s3_ff    <= cur_ff;
            endcase
         end
         if (cmd.fin_en) s4_ff <= y_new;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.load_sample) smp_ff <= sample_in;
      if (cmd.mul_op != mlf_pkg::MUL_NONE) prod_ff <= op_a * op_b;
      if (cmd.acc_load) acc_ff <= prod_ff;
      else if (cmd.acc_sub) acc_ff <= acc_ff - prod_ff;
      if (cmd.sum_en) sum_ff <= SW'(cur_ff) + SW'(prev_sel);
      if (cmd.x_en) cur_ff <= sat32(PW'(x_diff));
      else if (cmd.rnd_op == mlf_pkg::RND_STAGE) cur_ff <= rnd_val;
      if (cmd.rnd_op != mlf_pkg::RND_NONE && cmd.rnd_op != mlf_pkg::RND_STAGE)
         tmp_ff <= rnd_val;
      // output saturated to the sample range
      if (cmd.fin_en) begin
         if (y_wide > S_MAX)      out_ff <= S_MAX[SAMPLE_BITS-1:0];
         else if (y_wide < S_MIN) out_ff <= S_MIN[SAMPLE_BITS-1:0];
         else                     out_ff <= y_wide[SAMPLE_BITS-1:0];
      end
   end

   assign sample_out = out_ff;

endmodule

// ----- hw/rtl/moog_ladder_lowpass_filter.sv -----
// ----------------------------------------------------------------------------
// moog_ladder_lowpass_filter: four-pole resonant ladder lowpass filter
// Resonance feedback, four one-pole stages and a cubic soft clip over a
// shared multiplier, driven by a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one signed Q1.(SAMPLE_BITS-1) sample per request; each
//   request gives exactly one filtered sample on rsp_chan, in order.
//   csr_chan writes the coefficients p (index 0), k (index 1) and r
//   (index 2), signed Q(24-COEF_FRAC_BITS).COEF_FRAC_BITS; other indexes are ignored. Write
//   them only while no sample is in flight. csr_chan is always ready.
//   Requests are taken only while the sequencer is idle, so the filter works on
//   one sample at a time: the twelve products and their round steps go in
//   order through the one multiplier before the next request is accepted.
//   The output register lets the next request be accepted while a result
//   still waits. If the receiver stalls, the following result holds in the
//   last step until the output register is free, and requests stop.
//   Reset (synchronous, active high) clears coefficients and filter state
//   to zero and drops rsp valid.
// ----------------------------------------------------------------------------
module moog_ladder_lowpass_filter #(
   parameter int SAMPLE_BITS    = mlf_pkg::SAMPLE_BITS_DEF,
   parameter int COEF_FRAC_BITS = mlf_pkg::COEF_FRAC_BITS_DEF
) (
   input logic   clock,
   input logic   reset,
   mlf_req_if.sink   req_chan,
   mlf_rsp_if.source rsp_chan,
   mlf_csr_if.sink   csr_chan
);

   mlf_pkg::cmd_type cmd;

   assign csr_chan.ready = 1'b1;

   // sequencer
   mlf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   // arithmetic and state
   mlf_datapath #(
      .SAMPLE_BITS    (SAMPLE_BITS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sample_in  (req_chan.sample_in),
      .csr_write  (csr_chan.valid),
      .csr_index  (csr_chan.reg_index),
      .csr_wdata  (csr_chan.wdata),
      .sample_out (rsp_chan.sample_out)
   );

endmodule
